@@ hdl/lshc_pkg.sv @@
// Shared types and constants for the lane sweep heading controller.
package lshc_pkg;

    // Datapath widths
    localparam int ALU_W    = 48;
    localparam int YAW_W    = 48;
    localparam int RATE_W   = 17;
    localparam int PROD_W   = 28;
    localparam int ACC_W    = 47;
    localparam int DVS_W    = 35;
    localparam int MAG_W    = 10;
    localparam int DRV_W    = 9;
    localparam int SUM_W    = 12;
    localparam int CNT_W    = 4;
    localparam int KP_W     = 12;
    localparam int DIST_W   = 14;
    localparam int PULSE_W  = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 24;

    // Yaw units: raw count times ms; one degree is 131000 units
    localparam logic [ALU_W-1:0] QUARTER_UNITS = 48'd11790000;
    localparam logic [ALU_W-1:0] TOL_UNITS     = 48'd393000;
    // Correction divisor: 256 * 131000, and the quotient limit 1024 * divisor
    localparam logic [ALU_W-1:0] DIV_LIMIT     = 48'd34340864000;
    localparam logic [DVS_W-1:0] DVS_START     = 35'd17170432000;
    localparam logic [CNT_W-1:0] MUL_STEPS_M1  = 4'd11;
    localparam logic [CNT_W-1:0] DIV_STEPS_M1  = 4'd9;
    localparam logic [MAG_W-1:0] MAG_SAT       = 10'd1023;
    localparam logic [DIST_W-1:0] LANE_FRONT_MM = 14'd150;
    localparam logic signed [SUM_W-1:0] DRIVE_MAX = 12'sd255;

    // Mode codes
    localparam logic [1:0] MODE_STRAIGHT = 2'd0;
    localparam logic [1:0] MODE_TURN1    = 2'd1;
    localparam logic [1:0] MODE_SHIFT    = 2'd2;
    localparam logic [1:0] MODE_TURN2    = 2'd3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GYRO_OFFSET   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_SPEED    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KP_GAIN       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FRONT_STOP_MM = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SIDE_STOP_MM  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LANE_PULSES   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TURN_SPEED    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_RATE_DEADBAND = 3'd7;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_PROD,
        S_ACC,
        S_ERR,
        S_ABS,
        S_DECIDE,
        S_TARGET,
        S_MUL,
        S_SAT,
        S_DIV,
        S_DRIVE,
        S_OUT
    } state_t;

endpackage

@@ hdl/lshc_addsub.sv @@
// Shared add/subtract unit with carry out (no-borrow flag on subtract).
module lshc_addsub (
    input  logic [lshc_pkg::ALU_W-1:0] a,
    input  logic [lshc_pkg::ALU_W-1:0] b,
    input  logic                       sub,
    output logic [lshc_pkg::ALU_W-1:0] sum,
    output logic                       carry
);
    import lshc_pkg::*;

    logic [ALU_W-1:0] b_op;
    logic [ALU_W:0]   full;

    // Invert b and add one for subtract
    assign b_op  = sub ? ~b : b;
    assign full  = {1'b0, a} + {1'b0, b_op} + {{ALU_W{1'b0}}, sub};
    assign sum   = full[ALU_W-1:0];
    assign carry = full[ALU_W];

endmodule

@@ hdl/lane_sweep_heading_controller.sv @@
// Top level: lane sweep controller with gyro heading hold on a shared adder.
//
//  channel | beat fields (low bit first)                                  | handshake
//  s_axis  | gyro_raw 16s, dt_ms 10, dist_left/mid/right_mm 14, new_pulses 8 | tvalid/tready
//  m_axis  | left_drive 9s, right_drive 9s, brake 1, mode 2                | tvalid/tready
//  cfg     | cfg_addr 3 = register index, cfg_wdata 16                     | cfg_we
//
// One beat is worked on at a time; s_tready is high only in idle.
// A tick goes from S_DECIDE to S_OUT for a spin or a finished turn, via S_TARGET for a
// lane exit, via S_DRIVE when the gain multiply is skipped (zero gain or a huge error)
// or the product saturates, and for full heading hold via the 12 shift-add steps of the
// gain multiply and the 10 restoring divide steps, all through the one 48-bit adder.
// Reset clears the sequencer, the sweep state and loads the register defaults.
// A result waits in the output register while the next beat is accepted; the
// sequencer holds in its last step until that register is free.
module lane_sweep_heading_controller (
    input  logic                                clk,
    input  logic                                rst_n,
    // gyro_raw[15:0], dt_ms[25:16], dist_left_mm[39:26], dist_mid_mm[53:40],
    // dist_right_mm[67:54], new_pulses[75:68], zero fill[79:76]
    input  logic [lshc_pkg::IN_DATA_W-1:0]      s_tdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // left_drive[8:0], right_drive[17:9], brake[18], mode[20:19], zero fill[23:21]
    output logic [lshc_pkg::OUT_DATA_W-1:0]     m_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic                                cfg_we,
    input  logic [lshc_pkg::CFG_IDX_W-1:0]      cfg_addr,
    input  logic [lshc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    import lshc_pkg::*;

    // Configuration registers
    logic signed [15:0]   gyro_offset_reg;
    logic [7:0]           base_speed_reg;
    logic [KP_W-1:0]      kp_gain_reg;
    logic [DIST_W-1:0]    front_stop_reg;
    logic [DIST_W-1:0]    side_stop_reg;
    logic [PULSE_W-1:0]   lane_pulses_reg;
    logic [7:0]           turn_speed_reg;
    logic [14:0]          deadband_reg;

    // Sequencer and tick state
    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     cnt_reg;
    logic signed [RATE_W-1:0] rate_reg;
    logic [9:0]           dt_reg;
    logic [DIST_W-1:0]    dl_reg, dm_reg, dr_reg;
    logic [7:0]           np_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic                 integ_reg;
    logic [YAW_W-1:0]     yaw_reg;
    logic [YAW_W-1:0]     target_reg;
    logic                 sweep_neg_reg;
    logic [PULSE_W-1:0]   pulse_reg;
    logic [1:0]           mode_reg;
    logic [ALU_W-1:0]     err_reg;
    logic [ALU_W-1:0]     eabs_reg;
    logic [ACC_W-1:0]     acc_reg;
    logic [DVS_W-1:0]     dvs_reg;
    logic [MAG_W-1:0]     mag_reg;
    logic [DRV_W-1:0]     left_res_reg, right_res_reg;
    logic                 brake_res_reg;

    // Output register
    logic                 m_valid_reg;
    logic [OUT_DATA_W-1:0] m_data_reg;

    // Shared adder operands
    logic [ALU_W-1:0]     alu_a, alu_b, alu_sum;
    logic                 alu_sub, alu_carry;

    // Decode helpers
    logic signed [RATE_W-1:0] rate_in;
    logic [RATE_W-1:0]    rate_abs;
    logic signed [PROD_W-1:0] prod_full;
    logic [PULSE_W:0]     pulse_sum;
    logic                 within_tol;
    logic                 leave_straight, leave_shift;
    logic                 hold_big;
    logic                 out_free;
    logic signed [SUM_W-1:0] base_s, mag_s, plus_s, minus_s;
    logic [DRV_W-1:0]     hold_left, hold_right;

    lshc_addsub u_addsub (
        .a     (alu_a),
        .b     (alu_b),
        .sub   (alu_sub),
        .sum   (alu_sum),
        .carry (alu_carry)
    );

    function automatic logic [DRV_W-1:0] clamp_drive(input logic signed [SUM_W-1:0] v);
        logic [DRV_W-1:0] r;
        begin
            if (v > DRIVE_MAX)
            begin
                r = DRIVE_MAX[DRV_W-1:0];
            end
            else if (v < -DRIVE_MAX)
            begin
                r = DRV_W'(-DRIVE_MAX);
            end
            else
            begin
                r = v[DRV_W-1:0];
            end
            return r;
        end
    endfunction

    // Rate, deadband magnitude and the integration product
    assign rate_in   = $signed({s_tdata[15], s_tdata[15:0]}) -
                       $signed({gyro_offset_reg[15], gyro_offset_reg});
    assign rate_abs  = rate_reg[RATE_W-1] ? RATE_W'(-rate_reg) : rate_reg;
    assign prod_full = PROD_W'(rate_reg) * PROD_W'($signed({1'b0, dt_reg}));
    assign pulse_sum = {1'b0, pulse_reg} + {9'd0, np_reg};

    // Mode decisions
    assign within_tol     = eabs_reg < TOL_UNITS;
    assign leave_straight = (dm_reg < front_stop_reg) || (dl_reg < side_stop_reg) ||
                            (dr_reg < side_stop_reg);
    assign leave_shift    = (pulse_reg >= lane_pulses_reg) || (dm_reg < LANE_FRONT_MM);
    assign hold_big       = eabs_reg[ALU_W-1:DVS_W] != '0;
    assign out_free       = !m_valid_reg || m_tready;

    // Heading hold drives: the correction takes its sign from the error
    assign base_s  = $signed({4'd0, base_speed_reg});
    assign mag_s   = $signed({2'd0, mag_reg});
    assign plus_s  = base_s + mag_s;
    assign minus_s = base_s - mag_s;
    assign hold_left  = err_reg[ALU_W-1] ? clamp_drive(plus_s)  : clamp_drive(minus_s);
    assign hold_right = err_reg[ALU_W-1] ? clamp_drive(minus_s) : clamp_drive(plus_s);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:   if (s_tvalid) state_next = S_PROD;
            S_PROD:   state_next = S_ACC;
            S_ACC:    state_next = S_ERR;
            S_ERR:    state_next = S_ABS;
            S_ABS:    state_next = S_DECIDE;
            S_DECIDE:
            begin
                if (mode_reg == MODE_STRAIGHT || mode_reg == MODE_SHIFT)
                begin
                    if ((mode_reg == MODE_STRAIGHT) ? leave_straight : leave_shift)
                        state_next = S_TARGET;
                    else if (kp_gain_reg == '0 || hold_big)
                        state_next = S_DRIVE;
                    else
                        state_next = S_MUL;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_TARGET: state_next = S_OUT;
            S_MUL:    if (cnt_reg == '0) state_next = S_SAT;
            S_SAT:    state_next = alu_carry ? S_DRIVE : S_DIV;
            S_DIV:    if (cnt_reg == '0) state_next = S_DRIVE;
            S_DRIVE:  state_next = S_OUT;
            S_OUT:    if (out_free) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // Adder operand select per step
    always_comb
    begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        case (state_reg)
            S_ACC:
            begin
                alu_a = yaw_reg;
                alu_b = {{(ALU_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
            end
            S_ERR:
            begin
                alu_a   = target_reg;
                alu_b   = yaw_reg;
                alu_sub = 1'b1;
            end
            S_ABS:
            begin
                alu_b   = err_reg;
                alu_sub = 1'b1;
            end
            S_TARGET:
            begin
                alu_a   = yaw_reg;
                alu_b   = QUARTER_UNITS;
                alu_sub = sweep_neg_reg;
            end
            S_MUL:
            begin
                alu_a = {1'b0, acc_reg[ACC_W-2:0], 1'b0};
                alu_b = kp_gain_reg[cnt_reg] ? eabs_reg : '0;
            end
            S_SAT:
            begin
                alu_a   = {1'b0, acc_reg};
                alu_b   = DIV_LIMIT;
                alu_sub = 1'b1;
            end
            S_DIV:
            begin
                alu_a   = {1'b0, acc_reg};
                alu_b   = {{(ALU_W-DVS_W){1'b0}}, dvs_reg};
                alu_sub = 1'b1;
            end
            default:
            begin
                alu_a   = '0;
                alu_b   = '0;
                alu_sub = 1'b0;
            end
        endcase
    end

    // Sequencer, sweep state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            cnt_reg         <= '0;
            yaw_reg         <= '0;
            target_reg      <= '0;
            sweep_neg_reg   <= 1'b0;
            pulse_reg       <= '0;
            mode_reg        <= MODE_STRAIGHT;
            gyro_offset_reg <= '0;
            base_speed_reg  <= 8'd80;
            kp_gain_reg     <= 12'd896;
            front_stop_reg  <= 14'd300;
            side_stop_reg   <= 14'd150;
            lane_pulses_reg <= 16'd20;
            turn_speed_reg  <= 8'd90;
            deadband_reg    <= 15'd131;
            m_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // Register writes
            if (cfg_we)
            begin
                case (cfg_addr)
                    REG_GYRO_OFFSET:   gyro_offset_reg <= $signed(cfg_wdata);
                    REG_BASE_SPEED:    base_speed_reg  <= cfg_wdata[7:0];
                    REG_KP_GAIN:       kp_gain_reg     <= cfg_wdata[KP_W-1:0];
                    REG_FRONT_STOP_MM: front_stop_reg  <= cfg_wdata[DIST_W-1:0];
                    REG_SIDE_STOP_MM:  side_stop_reg   <= cfg_wdata[DIST_W-1:0];
                    REG_LANE_PULSES:   lane_pulses_reg <= cfg_wdata;
                    REG_TURN_SPEED:    turn_speed_reg  <= cfg_wdata[7:0];
                    REG_RATE_DEADBAND: deadband_reg    <= cfg_wdata[14:0];
                    default: ;
                endcase
            end

            // Integrate yaw and add pulses with saturation
            if (state_reg == S_ACC)
            begin
                if (integ_reg)
                    yaw_reg <= alu_sum;
                pulse_reg <= pulse_sum[PULSE_W] ? {PULSE_W{1'b1}} : pulse_sum[PULSE_W-1:0];
            end

            // Mode changes at the end of a turn
            if (state_reg == S_DECIDE && (mode_reg == MODE_TURN1 || mode_reg == MODE_TURN2)
                && within_tol)
            begin
                target_reg <= yaw_reg;
                if (mode_reg == MODE_TURN1)
                begin
                    pulse_reg <= '0;
                    mode_reg  <= MODE_SHIFT;
                end
                else
                begin
                    sweep_neg_reg <= !sweep_neg_reg;
                    mode_reg      <= MODE_STRAIGHT;
                end
            end

            // Leave straight run or lane shift with a new quarter turn target
            if (state_reg == S_TARGET)
            begin
                target_reg <= alu_sum;
                mode_reg   <= mode_reg + 2'd1;
            end

            // Step counter for multiply and divide
            case (state_reg)
                S_DECIDE: cnt_reg <= MUL_STEPS_M1;
                S_SAT:    cnt_reg <= DIV_STEPS_M1;
                S_MUL, S_DIV: cnt_reg <= cnt_reg - 4'd1;
                default: ;
            endcase

            // Output register
            if (state_reg == S_OUT && out_free)
                m_valid_reg <= 1'b1;
            else if (m_tready)
                m_valid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && s_tvalid)
        begin
            rate_reg <= rate_in;
            dt_reg   <= s_tdata[25:16];
            dl_reg   <= s_tdata[39:26];
            dm_reg   <= s_tdata[53:40];
            dr_reg   <= s_tdata[67:54];
            np_reg   <= s_tdata[75:68];
        end

        case (state_reg)
            S_PROD:
            begin
                prod_reg  <= prod_full;
                integ_reg <= rate_abs > {2'd0, deadband_reg};
            end
            S_ERR:
            begin
                err_reg <= alu_sum;
            end
            S_ABS:
            begin
                eabs_reg <= err_reg[ALU_W-1] ? alu_sum : err_reg;
            end
            S_DECIDE:
            begin
                acc_reg       <= '0;
                mag_reg       <= (kp_gain_reg == '0) ? '0 : MAG_SAT;
                brake_res_reg <= 1'b0;
                left_res_reg  <= '0;
                right_res_reg <= '0;
                if (mode_reg == MODE_STRAIGHT || mode_reg == MODE_SHIFT)
                begin
                    if ((mode_reg == MODE_STRAIGHT) ? leave_straight : leave_shift)
                        brake_res_reg <= 1'b1;
                end
                else if (within_tol)
                begin
                    brake_res_reg <= 1'b1;
                end
                else if (!err_reg[ALU_W-1] && err_reg != '0)
                begin
                    left_res_reg  <= {1'b0, turn_speed_reg};
                    right_res_reg <= DRV_W'(-$signed({1'b0, turn_speed_reg}));
                end
                else
                begin
                    left_res_reg  <= DRV_W'(-$signed({1'b0, turn_speed_reg}));
                    right_res_reg <= {1'b0, turn_speed_reg};
                end
            end
            S_MUL:
            begin
                acc_reg <= alu_sum[ACC_W-1:0];
            end
            S_SAT:
            begin
                dvs_reg <= DVS_START;
                if (alu_carry)
                    mag_reg <= MAG_SAT;
                else
                    mag_reg <= '0;
            end
            S_DIV:
            begin
                dvs_reg <= dvs_reg >> 1;
                mag_reg <= {mag_reg[MAG_W-2:0], alu_carry};
                if (alu_carry)
                    acc_reg <= alu_sum[ACC_W-1:0];
            end
            S_DRIVE:
            begin
                left_res_reg  <= hold_left;
                right_res_reg <= hold_right;
            end
            default: ;
        endcase

        if (state_reg == S_OUT && out_free)
            m_data_reg <= {3'd0, mode_reg, brake_res_reg, right_res_reg, left_res_reg};
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule
